### design/hsl_adj_pkg.sv
// Package for the HSL pixel adjust block: pixel and configuration types,
// operation codes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package hsl_adj_pkg;

  localparam int unsigned HueW  = 13;
  localparam int unsigned FracW = 17;
  localparam int unsigned RotW  = 14;
  localparam int unsigned ModeW = 3;
  localparam int unsigned AddrW = 2;
  localparam int unsigned DataW = 17;
  localparam int unsigned TdataW = 48;

  localparam logic [FracW-1:0] ONE_FIX      = 17'h10000;
  localparam logic [FracW-1:0] AMOUNT_RESET = 17'd6554;
  localparam logic [14:0]      FULL_TURN    = 15'd5760;

  typedef enum logic [ModeW-1:0] {
    MODE_LIGHTEN    = 3'd0,
    MODE_DARKEN     = 3'd1,
    MODE_SATURATE   = 3'd2,
    MODE_DESATURATE = 3'd3,
    MODE_GRAYSCALE  = 3'd4,
    MODE_ROTATE     = 3'd5
  } mode_e;

  localparam logic [AddrW-1:0] REG_MODE     = 2'd0;
  localparam logic [AddrW-1:0] REG_AMOUNT   = 2'd1;
  localparam logic [AddrW-1:0] REG_ROTATION = 2'd2;

  // Packed so that hue lands in the lowest bits of tdata.
  typedef struct packed {
    logic [FracW-1:0] lum;
    logic [FracW-1:0] sat;
    logic [HueW-1:0]  hue;
  } pixel_t;

  typedef struct packed {
    logic [ModeW-1:0]       mode;
    logic [FracW-1:0]       amount;
    logic signed [RotW-1:0] rotation;
  } cfg_t;

endpackage

### design/hsl_adj_cfg.sv
// Configuration registers of the HSL pixel adjust block.
// Depends on hsl_adj_pkg.
`timescale 1ns / 1ps

module hsl_adj_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsl_adj_pkg::AddrW-1:0]  cfg_addr_i,
  input  logic [hsl_adj_pkg::DataW-1:0]  cfg_wdata_i,
  output hsl_adj_pkg::cfg_t              cfg_o
);
  import hsl_adj_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_LIGHTEN;
      cfg_q.amount   <= AMOUNT_RESET;
      cfg_q.rotation <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MODE:     cfg_q.mode     <= cfg_wdata_i[ModeW-1:0];
        REG_AMOUNT:   cfg_q.amount   <= cfg_wdata_i[FracW-1:0];
        REG_ROTATION: cfg_q.rotation <= $signed(cfg_wdata_i[RotW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

### design/hsl_adj_core.sv
// Combinational point operation on one HSL pixel: clamped add or subtract,
// grayscale and hue rotation with wrap. Depends on hsl_adj_pkg.
`timescale 1ns / 1ps

module hsl_adj_core (
  input  hsl_adj_pkg::pixel_t pix_i,
  input  hsl_adj_pkg::cfg_t   cfg_i,
  output hsl_adj_pkg::pixel_t pix_o
);
  import hsl_adj_pkg::*;

  logic [FracW:0]      add_lum, add_sat;
  logic [FracW-1:0]    lum_plus, lum_minus, sat_plus, sat_minus;
  logic [FracW-1:0]    lum_diff, sat_diff;
  logic signed [14:0]  hue_sum;
  logic [14:0]         hue_biased;
  logic [14:0]         hue_wrapped;

  // Saturating add and subtract, both clamped to 0..1.0.
  assign add_lum  = {1'b0, pix_i.lum} + {1'b0, cfg_i.amount};
  assign add_sat  = {1'b0, pix_i.sat} + {1'b0, cfg_i.amount};
  assign lum_plus = (add_lum >= {1'b0, ONE_FIX}) ? ONE_FIX : add_lum[FracW-1:0];
  assign sat_plus = (add_sat >= {1'b0, ONE_FIX}) ? ONE_FIX : add_sat[FracW-1:0];

  assign lum_diff  = pix_i.lum - cfg_i.amount;
  assign sat_diff  = pix_i.sat - cfg_i.amount;
  assign lum_minus = (pix_i.lum <= cfg_i.amount) ? '0 :
                     (lum_diff > ONE_FIX) ? ONE_FIX : lum_diff;
  assign sat_minus = (pix_i.sat <= cfg_i.amount) ? '0 :
                     (sat_diff > ONE_FIX) ? ONE_FIX : sat_diff;

  // The sum spans -8192..16382; biasing by two turns makes it positive and
  // below five turns, so at most four turns come off.
  assign hue_sum    = $signed({2'b00, pix_i.hue}) + $signed({cfg_i.rotation[RotW-1],
                                                           cfg_i.rotation});
  assign hue_biased = 15'(hue_sum) + 15'(2 * FULL_TURN);

  always_comb begin
    if (hue_biased >= 15'(4 * FULL_TURN)) begin
      hue_wrapped = hue_biased - 15'(4 * FULL_TURN);
    end else if (hue_biased >= 15'(3 * FULL_TURN)) begin
      hue_wrapped = hue_biased - 15'(3 * FULL_TURN);
    end else if (hue_biased >= 15'(2 * FULL_TURN)) begin
      hue_wrapped = hue_biased - 15'(2 * FULL_TURN);
    end else if (hue_biased >= FULL_TURN) begin
      hue_wrapped = hue_biased - FULL_TURN;
    end else begin
      hue_wrapped = hue_biased;
    end
  end

  always_comb begin
    pix_o = pix_i;
    case (cfg_i.mode)
      MODE_LIGHTEN:    pix_o.lum = lum_plus;
      MODE_DARKEN:     pix_o.lum = lum_minus;
      MODE_SATURATE:   pix_o.sat = sat_plus;
      MODE_DESATURATE: pix_o.sat = sat_minus;
      MODE_GRAYSCALE:  pix_o.sat = '0;
      MODE_ROTATE:     pix_o.hue = hue_wrapped[HueW-1:0];
      default: ;
    endcase
  end

endmodule

### design/hsl_pixel_adjust.sv
// HSL pixel adjust, top level: input register, point operation, result register.
// Input register, then result register; one pixel per cycle while m_axis_tready is high.
// The point operation is the single combinational pass between the two registers.
// Reset is asynchronous, active low: both stages empty, mode lighten, amount 0.1,
// rotation 0. Depends on hsl_adj_pkg, hsl_adj_cfg and hsl_adj_core.
`timescale 1ns / 1ps

module hsl_pixel_adjust (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: hue_in[12:0], sat_in[29:13], lum_in[46:30], zero.
  input  logic [hsl_adj_pkg::TdataW-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: hue_out[12:0], sat_out[29:13], lum_out[46:30], zero.
  output logic [hsl_adj_pkg::TdataW-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsl_adj_pkg::AddrW-1:0]  cfg_addr_i,
  input  logic [hsl_adj_pkg::DataW-1:0]  cfg_wdata_i
);
  import hsl_adj_pkg::*;

  cfg_t   cfg;
  pixel_t in_pix_q, out_pix_q, core_pix;
  logic   in_valid_q, out_valid_q;
  logic   in_ready, out_ready;

  hsl_adj_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  hsl_adj_core u_core (
    .pix_i(in_pix_q),
    .cfg_i(cfg),
    .pix_o(core_pix)
  );

  // Each stage takes a new request when it is empty or its content moves on.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW - $bits(pixel_t)){1'b0}}, out_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_pix_q <= s_axis_tdata[$bits(pixel_t)-1:0];
    end
    if (out_ready && in_valid_q) begin
      out_pix_q <= core_pix;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input side stalled while the result register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted request did not reach the input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && cfg.mode == MODE_ROTATE) |-> (15'(core_pix.hue) < FULL_TURN))
    else $error("rotated hue left the range of one turn");

endmodule

### verif/tb_hsl_pixel_adjust.sv
// Self-checking testbench for hsl_pixel_adjust: directed table, then random phases.
// Each accepted pixel is predicted in the bench and compared with the stream output.
// Depends on hsl_adj_pkg and the hsl_pixel_adjust RTL.
`timescale 1ns / 1ps

module tb_hsl_pixel_adjust;
  import hsl_adj_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PhaseCount = 14;
  localparam int unsigned PhaseItems = 88;
  localparam int unsigned ReportCap  = 40;

  // The mode register is three bits wide; the top two codes select no operation.
  localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [AddrW-1:0] REG_SPARE    = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]       mode;
    logic [FracW-1:0]       amount;
    logic signed [RotW-1:0] rotation;
    pixel_t                 px;
    logic                   typed;
    pixel_t                 want;
  } vector_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tready = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic [AddrW-1:0]  cfg_addr_i    = '0;
  logic [DataW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [TdataW-1:0] m_axis_tdata;
  logic              cfg_ready_o;

  // Bench copy of the configuration, updated on each accepted register write.
  logic [ModeW-1:0]       cur_mode     = MODE_LIGHTEN;
  logic [FracW-1:0]       cur_amount   = AMOUNT_RESET;
  logic signed [RotW-1:0] cur_rotation = '0;

  pixel_t pending_pixels[$];
  int     mismatches   = 0;
  int     pixels_sent  = 0;
  int     results_seen = 0;
  int     reg_writes   = 0;
  bit     idling       = 1'b1;
  int     stall_left   = 0;

  always #5 clk_i = ~clk_i;

  hsl_pixel_adjust DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic pixel_t pix(int hue, int sat, int lum);
    pixel_t p;
    p.hue = HueW'(hue);
    p.sat = FracW'(sat);
    p.lum = FracW'(lum);
    return p;
  endfunction

  function automatic logic [FracW-1:0] raise_clamped(logic [FracW-1:0] v);
    logic [FracW:0] total;
    total = {1'b0, v} + {1'b0, cur_amount};
    return (total >= {1'b0, ONE_FIX}) ? ONE_FIX : total[FracW-1:0];
  endfunction

  // Inputs above 1.0 can still leave more than 1.0 after the subtraction.
  function automatic logic [FracW-1:0] lower_clamped(logic [FracW-1:0] v);
    logic [FracW-1:0] diff;
    if (v <= cur_amount) return '0;
    diff = v - cur_amount;
    return (diff > ONE_FIX) ? ONE_FIX : diff;
  endfunction

  function automatic pixel_t adjusted_pixel(pixel_t px);
    pixel_t r;
    int     turn;
    r = px;
    case (cur_mode)
      MODE_LIGHTEN:    r.lum = raise_clamped(px.lum);
      MODE_DARKEN:     r.lum = lower_clamped(px.lum);
      MODE_SATURATE:   r.sat = raise_clamped(px.sat);
      MODE_DESATURATE: r.sat = lower_clamped(px.sat);
      MODE_GRAYSCALE:  r.sat = '0;
      MODE_ROTATE: begin
        turn = (int'(px.hue) + int'(cur_rotation)) % int'(FULL_TURN);
        if (turn < 0) turn += int'(FULL_TURN);
        r.hue = HueW'(turn);
      end
      default: r = px;
    endcase
    return r;
  endfunction

  // Biased toward the clamp edges of the current amount.
  function automatic logic [FracW-1:0] random_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE_FIX;
      2:       return FracW'($urandom);
      3:       return cur_amount;
      4:       return ONE_FIX - cur_amount + FracW'($urandom_range(0, 2)) - 17'd1;
      default: return FracW'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < ReportCap) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write of a group.
  task automatic write_reg(logic [AddrW-1:0] idx, logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:     cur_mode = val[ModeW-1:0];
      REG_AMOUNT:   cur_amount = val[FracW-1:0];
      REG_ROTATION: cur_rotation = val[RotW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_pixel(pixel_t px, logic typed, pixel_t want);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataW'(px);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(typed ? want : adjusted_pixel(px));
    pixels_sent++;
  endtask

  // Holds off new pixels until every pending result has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 6) == 0) begin
      stall_left    <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pixel_t'(m_axis_tdata[$bits(pixel_t)-1:0]);
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result with no pending pixel, tdata %h", m_axis_tdata));
      end else begin
        want = pending_pixels.pop_front();
        if (got.hue !== want.hue)
          report_mismatch($sformatf("result %0d hue_out %0d, predicted %0d",
                                    results_seen, got.hue, want.hue));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("result %0d sat_out %0d, predicted %0d",
                                    results_seen, got.sat, want.sat));
        if (got.lum !== want.lum)
          report_mismatch($sformatf("result %0d lum_out %0d, predicted %0d",
                                    results_seen, got.lum, want.lum));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR @%0t: no request accepted for %0d cycles", $time, QuietLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    vector_t                directed [25];
    pixel_t                 px;
    pixel_t                 lost;
    logic [ModeW-1:0]       mode_sel;
    logic [FracW-1:0]       amount_sel;
    logic signed [RotW-1:0] rot_sel;

    // mode, amount, rotation, pixel (hue, sat, lum), typed, expected pixel
    directed = '{
      '{MODE_LIGHTEN, AMOUNT_RESET, 14'sd0, pix(0, 0, 0), 1'b1, pix(0, 0, 6554)},
      '{MODE_LIGHTEN, AMOUNT_RESET, 14'sd0, pix(5759, 65536, 65536), 1'b1,
        pix(5759, 65536, 65536)},
      '{MODE_LIGHTEN, AMOUNT_RESET, 14'sd0, pix(1, 2, 60000), 1'b1, pix(1, 2, 65536)},
      '{MODE_LIGHTEN, AMOUNT_RESET, 14'sd0, pix(8191, 131071, 131071), 1'b1,
        pix(8191, 131071, 65536)},
      '{MODE_DARKEN, 17'd100, 14'sd0, pix(3, 4, 70000), 1'b1, pix(3, 4, 65536)},
      '{MODE_DARKEN, 17'd100, 14'sd0, pix(0, 0, 100), 1'b1, pix(0, 0, 0)},
      '{MODE_DARKEN, 17'd100, 14'sd0, pix(0, 0, 101), 1'b1, pix(0, 0, 1)},
      '{MODE_DARKEN, 17'd0, 14'sd0, pix(0, 0, 131071), 1'b1, pix(0, 0, 65536)},
      '{MODE_SATURATE, 17'd65536, 14'sd0, pix(0, 0, 0), 1'b1, pix(0, 65536, 0)},
      '{MODE_SATURATE, 17'd131071, 14'sd0, pix(5759, 131071, 5), 1'b1,
        pix(5759, 65536, 5)},
      '{MODE_DESATURATE, 17'd131071, 14'sd0, pix(7, 65536, 9), 1'b1, pix(7, 0, 9)},
      '{MODE_DESATURATE, AMOUNT_RESET, 14'sd0, pix(0, 30000, 0), 1'b1, pix(0, 23446, 0)},
      '{MODE_DESATURATE, AMOUNT_RESET, 14'sd0, pix(0, 131071, 0), 1'b1,
        pix(0, 65536, 0)},
      '{MODE_GRAYSCALE, AMOUNT_RESET, 14'sd0, pix(4000, 131071, 131071), 1'b1,
        pix(4000, 0, 131071)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sd0, pix(0, 1, 2), 1'b1, pix(0, 1, 2)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sd0, pix(8191, 0, 0), 1'b1, pix(2431, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sd5760, pix(0, 0, 0), 1'b1, pix(0, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, -14'sd5760, pix(0, 0, 0), 1'b1, pix(0, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, -14'sd1, pix(0, 0, 0), 1'b1, pix(5759, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sd1, pix(5759, 0, 0), 1'b1, pix(0, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sh1FFF, pix(8191, 0, 0), 1'b1, pix(4862, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sh2000, pix(0, 0, 0), 1'b1, pix(3328, 0, 0)},
      '{MODE_ROTATE, AMOUNT_RESET, 14'sd1000, pix(5000, 12345, 54321), 1'b0, '0},
      '{MODE_SPARE_6, AMOUNT_RESET, 14'sd1000, pix(8191, 131071, 131071), 1'b1,
        pix(8191, 131071, 131071)},
      '{MODE_SPARE_7, AMOUNT_RESET, 14'sd1000, pix(0, 0, 0), 1'b1, pix(0, 0, 0)}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].mode != cur_mode || directed[i].amount != cur_amount ||
          directed[i].rotation != cur_rotation) begin
        drain();
        if (directed[i].mode != cur_mode) write_reg(REG_MODE, DataW'(directed[i].mode));
        if (directed[i].amount != cur_amount) write_reg(REG_AMOUNT, directed[i].amount);
        if (directed[i].rotation != cur_rotation)
          write_reg(REG_ROTATION, {3'b000, directed[i].rotation});
        cfg_valid_i <= 1'b0;
      end
      send_pixel(directed[i].px, directed[i].typed, directed[i].want);
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // Some phases run without any idling, and the last ones never idle.
      idling   = (phase < PhaseCount - 3) && (phase % 4 != 2);
      mode_sel = (phase < 8) ? ModeW'(phase) : ModeW'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0:       amount_sel = '0;
        1:       amount_sel = ONE_FIX;
        2:       amount_sel = '1;
        3:       amount_sel = AMOUNT_RESET;
        4:       amount_sel = FracW'($urandom_range(1, 64));
        5:       amount_sel = FracW'($urandom);
        default: amount_sel = FracW'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 7))
        0:       rot_sel = 14'sh2000;
        1:       rot_sel = 14'sh1FFF;
        2:       rot_sel = 14'sd5760;
        3:       rot_sel = -14'sd5760;
        4:       rot_sel = '0;
        5:       rot_sel = RotW'($urandom);
        default: rot_sel = RotW'(int'($urandom_range(0, 11520)) - 5760);
      endcase

      drain();
      // Upper data bits beyond each register's width are junk and must be ignored.
      write_reg(REG_MODE, {14'($urandom), mode_sel});
      write_reg(REG_AMOUNT, amount_sel);
      write_reg(REG_ROTATION, {3'($urandom), rot_sel});
      if (phase % 5 == 1) write_reg(REG_SPARE, DataW'($urandom));
      cfg_valid_i <= 1'b0;

      repeat (PhaseItems) begin
        if ($urandom_range(0, 149) == 0) drain();
        px.hue = ($urandom_range(0, 9) == 0) ? HueW'($urandom_range(0, 8191))
                                              : HueW'($urandom_range(0, 5759));
        px.sat = random_fraction();
        px.lum = random_fraction();
        send_pixel(px, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (pending_pixels.size() != 0) begin
      lost = pending_pixels.pop_front();
      report_mismatch($sformatf("pixel never came out, hue %0d", lost.hue));
    end

    $display("Sent %0d pixels through %0d register writes covering all eight mode codes,",
             pixels_sent, reg_writes);
    $display("clamp edges, hue wrap at both ends and over-range fields; %0d results checked.",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
